// ===== rtl/tcpd_pkg.sv =====
// Shared types and constants for the thermocouple poll and change-detect unit.
// Used by the interfaces, the decoder, the controller and the top level.
// No dependencies.
package tcpd_pkg;

    // Request limit and field widths.
    localparam int MAX_PENDING = 15;
    localparam int PEND_W      = $clog2(MAX_PENDING + 1);
    localparam int TEMP_W      = 21;
    localparam int PERIOD_W    = 16;
    localparam int WORD_W      = 16;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 21;

    // Converter word layout and temperature scaling.
    localparam int COUNT_LSB      = 3;
    localparam int COUNT_MSB      = 14;
    localparam int COUNT_W        = COUNT_MSB - COUNT_LSB + 1;
    localparam int FAULT_BIT      = 2;
    localparam int MK_PER_COUNT   = 250;
    localparam int TEMP_OFFSET_MK = 273150;

    // Configuration register reset values.
    localparam logic [TEMP_W-1:0]   DELTA_RESET  = TEMP_W'(200);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_DELTA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD  = CFG_IDX_W'(1);

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_READ = 2'd0,
        OP_WAIT = 2'd1,
        OP_WORD = 2'd2,
        OP_TICK = 2'd3
    } t_op;

    // Poll mode, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_READING = 3'b010,
        MODE_WAITING = 3'b100
    } t_mode;

    // One result word.
    typedef struct packed {
        logic              start_read;
        logic              measurement_valid;
        logic [TEMP_W-1:0] temperature_mk;
        logic              open_fault;
        logic [PEND_W-1:0] reads_completed;
        logic [PEND_W-1:0] waits_completed;
        logic              request_refused;
    } t_result;

    // Controller status seen by the top level.
    typedef struct packed {
        t_mode             mode;
        logic [PEND_W-1:0] pend_reads;
        logic [PEND_W-1:0] pend_waits;
    } t_status;

endpackage

// ===== rtl/tcpd_in_if.sv =====
// Input channel of the thermocouple poll unit: valid/ready plus one request word.
// Depends on tcpd_pkg for field widths.
interface tcpd_in_if;
    import tcpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] raw_word;

    modport source (output valid, output op, output raw_word, input ready);
    modport sink   (input valid, input op, input raw_word, output ready);
endinterface

// ===== rtl/tcpd_out_if.sv =====
// Output channel of the thermocouple poll unit: valid/ready plus one result word.
// Depends on tcpd_pkg for field widths.
interface tcpd_out_if;
    import tcpd_pkg::*;

    logic              valid;
    logic              ready;
    logic              start_read;
    logic              measurement_valid;
    logic [TEMP_W-1:0] temperature_mk;
    logic              open_fault;
    logic [PEND_W-1:0] reads_completed;
    logic [PEND_W-1:0] waits_completed;
    logic              request_refused;

    modport source (
        output valid, output start_read, output measurement_valid,
        output temperature_mk, output open_fault, output reads_completed,
        output waits_completed, output request_refused, input ready
    );
    modport sink (
        input valid, input start_read, input measurement_valid,
        input temperature_mk, input open_fault, input reads_completed,
        input waits_completed, input request_refused, output ready
    );
endinterface

// ===== rtl/tcpd_decode.sv =====
// Converter word decoder: temperature in millikelvin and the open-probe flag.
// Depends on tcpd_pkg.
module tcpd_decode (
    input  logic [tcpd_pkg::WORD_W-1:0] i_raw_word,
    output logic [tcpd_pkg::TEMP_W-1:0] o_temperature_mk,
    output logic                        o_open_fault
);
    import tcpd_pkg::*;

    logic [COUNT_W-1:0] count;

    // Quarter-degree count scaled by a constant, then offset to kelvin.
    assign count            = i_raw_word[COUNT_MSB:COUNT_LSB];
    assign o_temperature_mk = TEMP_W'(count) * TEMP_W'(MK_PER_COUNT)
                            + TEMP_W'(TEMP_OFFSET_MK);
    assign o_open_fault     = i_raw_word[FAULT_BIT];
endmodule

// ===== rtl/tcpd_ctrl.sv =====
// Poll controller: mode, request counters, stored temperature and poll countdown.
// Depends on tcpd_pkg and tcpd_decode.
module tcpd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  tcpd_pkg::t_op                 i_op,
    input  logic [tcpd_pkg::WORD_W-1:0]   i_raw_word,
    input  logic [tcpd_pkg::TEMP_W-1:0]   i_change_delta,
    input  logic [tcpd_pkg::PERIOD_W-1:0] i_poll_period,
    output tcpd_pkg::t_result             o_result,
    output tcpd_pkg::t_status             o_status
);
    import tcpd_pkg::*;

    t_mode               r_mode,      n_mode;
    logic [TEMP_W-1:0]   r_last_temp, n_last_temp;
    logic [PEND_W-1:0]   r_pend_rd,   n_pend_rd;
    logic [PEND_W-1:0]   r_pend_wt,   n_pend_wt;
    logic [PERIOD_W-1:0] r_countdown, n_countdown;

    logic [TEMP_W-1:0] dec_temp;
    logic              dec_fault;
    logic [TEMP_W-1:0] diff;
    logic              changed;

    tcpd_decode u_decode (
        .i_raw_word       (i_raw_word),
        .o_temperature_mk (dec_temp),
        .o_open_fault     (dec_fault)
    );

    // Distance between the stored and the new temperature.
    assign diff    = (r_last_temp >= dec_temp) ? (r_last_temp - dec_temp)
                                               : (dec_temp - r_last_temp);
    assign changed = (diff >= i_change_delta);

    // Next state and result of the word in the input register.
    always_comb begin
        n_mode      = r_mode;
        n_last_temp = r_last_temp;
        n_pend_rd   = r_pend_rd;
        n_pend_wt   = r_pend_wt;
        n_countdown = r_countdown;
        o_result    = '0;
        case (i_op)
            OP_READ: begin
                if (r_pend_rd >= PEND_W'(MAX_PENDING)) begin
                    o_result.request_refused = 1'b1;
                end else begin
                    n_pend_rd = r_pend_rd + PEND_W'(1);
                    if (r_mode == MODE_IDLE) begin
                        n_mode              = MODE_READING;
                        o_result.start_read = 1'b1;
                    end
                end
            end
            OP_WAIT: begin
                if (r_pend_wt >= PEND_W'(MAX_PENDING)) begin
                    o_result.request_refused = 1'b1;
                end else begin
                    n_pend_wt = r_pend_wt + PEND_W'(1);
                end
            end
            OP_WORD: begin
                // A converter word outside a read is dropped.
                if (r_mode == MODE_READING) begin
                    o_result.measurement_valid = 1'b1;
                    o_result.temperature_mk    = dec_temp;
                    o_result.open_fault        = dec_fault;
                    o_result.reads_completed   = r_pend_rd;
                    n_pend_rd                  = '0;
                    if (changed) begin
                        n_last_temp = dec_temp;
                    end
                    if (changed || dec_fault) begin
                        o_result.waits_completed = r_pend_wt;
                        n_pend_wt                = '0;
                    end
                    n_mode      = MODE_WAITING;
                    n_countdown = i_poll_period;
                end
            end
            OP_TICK: begin
                // A zero period behaves like one tick.
                if (r_mode == MODE_WAITING) begin
                    if (r_countdown <= PERIOD_W'(1)) begin
                        n_countdown = '0;
                        n_mode      = MODE_IDLE;
                        if (r_pend_rd != '0 || r_pend_wt != '0) begin
                            n_mode              = MODE_READING;
                            o_result.start_read = 1'b1;
                        end
                    end else begin
                        n_countdown = r_countdown - PERIOD_W'(1);
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    // State advances only when the word moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_last_temp <= '0;
            r_pend_rd   <= '0;
            r_pend_wt   <= '0;
            r_countdown <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_last_temp <= n_last_temp;
            r_pend_rd   <= n_pend_rd;
            r_pend_wt   <= n_pend_wt;
            r_countdown <= n_countdown;
        end
    end

    assign o_status.mode       = r_mode;
    assign o_status.pend_reads = r_pend_rd;
    assign o_status.pend_waits = r_pend_wt;
endmodule

// ===== rtl/thermocouple_poll_change_detect_unit.sv =====
// Top level of the thermocouple poll and change-detect unit.
// Depends on tcpd_pkg, tcpd_in_if, tcpd_out_if, tcpd_ctrl and tcpd_decode.
//
// Usage:
//   i_req carries one word per handshake: a read request, a wait-for-change
//   request, a converter word, or a time tick. o_rsp returns exactly one result
//   word for each accepted word, in order. Configuration (change delta, poll
//   period) is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
//   write it only while the unit is idle, which the block does not enforce.
// Timing:
//   An accepted word sits in the input register, where the controller logic
//   processes it, and its result is registered in the result register when
//   the word moves on; o_rsp.valid then rises. One word is taken every cycle
//   while the receiver keeps ready high; the controller state is updated by a
//   single pass of logic between the input register and the result register.
// Reset and stalls:
//   Reset empties both registers, sets the mode to idle, clears the counters
//   and the stored temperature, and loads the configuration defaults. When the
//   receiver holds ready low, the result register keeps its word and the input
//   register keeps at most one more; i_req.ready drops once both are full.
module thermocouple_poll_change_detect_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tcpd_in_if.sink                        i_req,
    tcpd_out_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [tcpd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcpd_pkg::*;

    logic [TEMP_W-1:0]   r_change_delta;
    logic [PERIOD_W-1:0] r_poll_period;

    logic              r_in_valid;
    t_op               r_in_op;
    logic [WORD_W-1:0] r_in_word;
    logic              r_out_valid;
    t_result           r_out;

    logic    advance;
    logic    fire;
    logic    in_accept;
    t_result result;
    t_status status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_change_delta <= DELTA_RESET;
            r_poll_period  <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANGE_DELTA: r_change_delta <= i_cfg_data[TEMP_W-1:0];
                CFG_POLL_PERIOD:  r_poll_period  <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                    r_change_delta <= r_change_delta;
                end
            endcase
        end
    end

    // Handshake: the result register drains or is empty, so the input moves on.
    assign advance     = !r_out_valid || o_rsp.ready;
    assign fire        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;
    assign in_accept   = i_req.valid && i_req.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= t_op'(i_req.op);
            r_in_word <= i_req.raw_word;
        end
    end

    tcpd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (r_in_op),
        .i_raw_word     (r_in_word),
        .i_change_delta (r_change_delta),
        .i_poll_period  (r_poll_period),
        .o_result       (result),
        .o_status       (status)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.start_read        = r_out.start_read;
    assign o_rsp.measurement_valid = r_out.measurement_valid;
    assign o_rsp.temperature_mk    = r_out.temperature_mk;
    assign o_rsp.open_fault        = r_out.open_fault;
    assign o_rsp.reads_completed   = r_out.reads_completed;
    assign o_rsp.waits_completed   = r_out.waits_completed;
    assign o_rsp.request_refused   = r_out.request_refused;

    // The pending counters never pass their limit.
    a_pend_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.pend_reads <= PEND_W'(MAX_PENDING))
        && (status.pend_waits <= PEND_W'(MAX_PENDING)))
        else $error("pending request counter above limit");

    // A result never both starts a read and delivers a measurement.
    a_start_vs_meas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.start_read && r_out.measurement_valid))
        else $error("start_read together with a measurement");

    // Entering the waiting mode takes a converter word processed the cycle before.
    a_wait_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.mode == MODE_WAITING && $past(status.mode) != MODE_WAITING)
        |-> $past(fire && r_in_op == OP_WORD))
        else $error("waiting mode entered without a converter word");

    // A delivered measurement leaves no pending read behind.
    a_reads_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && result.measurement_valid) |=> (status.pend_reads == '0))
        else $error("pending reads left after a measurement");
endmodule
